### hw/rtl/gmb_pkg.sv
// Greedy meshlet builder: shared types and constants.
// Payload structs for both channels and the slot-assignment bundle.
// No dependencies.
`timescale 1ns / 1ps

package gmb_pkg;

	localparam int CORNER_W = 16;
	localparam int SLOT_W   = 8;
	localparam int LOCAL_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int CFG_W    = 17;
	localparam int NUM_W    = 16;

	localparam logic [SLOT_W-1:0] SLOT_UNUSED = 8'hff;
	localparam logic [CFG_W-1:0]  CFG_RESET   = 17'd65536;

	localparam logic OP_TRI = 1'b0;
	localparam logic OP_END = 1'b1;

	typedef struct packed {
		logic                opcode;
		logic [CORNER_W-1:0] corner_a;
		logic [CORNER_W-1:0] corner_b;
		logic [CORNER_W-1:0] corner_c;
	} item_t;

	typedef struct packed {
		logic               closed;
		logic [COUNT_W-1:0] closed_vertices;
		logic [COUNT_W-1:0] closed_triangles;
		logic [NUM_W-1:0]   meshlet_number;
		logic [LOCAL_W-1:0] local_a;
		logic [LOCAL_W-1:0] local_b;
		logic [LOCAL_W-1:0] local_c;
		logic [2:0]         new_mask;
		logic               index_error;
	} result_t;

	typedef struct packed {
		logic [2:0][SLOT_W-1:0] slot;
		logic [2:0]             fresh;
	} slot_assign_t;

endpackage

### hw/rtl/gmb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/gmb_slot_assign.sv
// Local slot assignment for the three corners of one triangle.
// Resolves repeated corners against earlier ones in a, b, c order. Uses gmb_pkg.
`timescale 1ns / 1ps

module gmb_slot_assign import gmb_pkg::*; #(
	parameter int VCAP = 64,
	parameter int VCW  = 7
) (
	input  logic [2:0][CORNER_W-1:0] corner,
	input  logic [2:0][SLOT_W-1:0]   slot_rd,
	input  logic                     cleared,
	input  logic [VCW-1:0]           vcnt,
	output slot_assign_t             asg
);

	localparam logic [VCW-1:0] VCAP_V = VCW'(VCAP);

	logic [2:0]     unused;
	logic [VCW-1:0] base1;
	logic [VCW-1:0] base2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			unused[k] = cleared || (slot_rd[k] == SLOT_UNUSED);
		end

		asg.fresh[0] = unused[0] && (vcnt < VCAP_V);
		asg.slot[0]  = asg.fresh[0] ? SLOT_W'(vcnt) :
			(unused[0] ? SLOT_UNUSED : slot_rd[0]);
		base1 = vcnt + VCW'(asg.fresh[0]);

		if (corner[1] == corner[0]) begin
			asg.fresh[1] = 1'b0;
			asg.slot[1]  = asg.slot[0];
		end else begin
			asg.fresh[1] = unused[1] && (base1 < VCAP_V);
			asg.slot[1]  = asg.fresh[1] ? SLOT_W'(base1) :
				(unused[1] ? SLOT_UNUSED : slot_rd[1]);
		end
		base2 = base1 + VCW'(asg.fresh[1]);

		if (corner[2] == corner[0]) begin
			asg.fresh[2] = 1'b0;
			asg.slot[2]  = asg.slot[0];
		end else if (corner[2] == corner[1]) begin
			asg.fresh[2] = 1'b0;
			asg.slot[2]  = asg.slot[1];
		end else begin
			asg.fresh[2] = unused[2] && (base2 < VCAP_V);
			asg.slot[2]  = asg.fresh[2] ? SLOT_W'(base2) :
				(unused[2] ? SLOT_UNUSED : slot_rd[2]);
		end
	end

endmodule

### hw/rtl/greedy_meshlet_builder_core.sv
// Greedy meshlet builder top level: sequencer, slot map and vertex list memories.
// Uses gmb_pkg, gmb_ram and gmb_slot_assign.
`timescale 1ns / 1ps

// After reset the slot map is swept to "unused", one entry per cycle; items are
// held off until the sweep ends, register writes are taken at any time. The
// slot map has a single read port, so the three corner lookups are serialized
// over ST_IDLE, ST_RB and ST_RC; the triangle is then judged in ST_EVAL and each
// new vertex is written in ST_WRITE. Closing a meshlet walks its vertex list to
// free the map entries, then resolves the triangle again in ST_RESOLVE. An
// out-of-range triangle goes straight to ST_DONE; so does an end item, which
// first walks the vertex list when a meshlet is open. One result per item; the
// next item is taken while a result waits in the output register.
module greedy_meshlet_builder_core import gmb_pkg::*; #(
	parameter int MAX_MESH_VERTICES    = 65536,
	parameter int MESHLET_VERTEX_CAP   = 64,
	parameter int MESHLET_TRIANGLE_CAP = 126
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result
);

	localparam int MAW  = $clog2(MAX_MESH_VERTICES);
	localparam int VCW  = $clog2(MESHLET_VERTEX_CAP + 1);
	localparam int LAW  = $clog2(MESHLET_VERTEX_CAP);
	localparam int TCW  = $clog2(MESHLET_TRIANGLE_CAP + 1);
	localparam int SUMW = VCW + 2;

	localparam logic [MAW-1:0]  CLR_LAST = MAW'(MAX_MESH_VERTICES - 1);
	localparam logic [31:0]     MAXV     = 32'(MAX_MESH_VERTICES);
	localparam logic [SUMW-1:0] VCAP_S   = SUMW'(MESHLET_VERTEX_CAP);
	localparam logic [TCW-1:0]  TCAP_V   = TCW'(MESHLET_TRIANGLE_CAP);

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b00_0000_0001,
		ST_IDLE    = 10'b00_0000_0010,
		ST_RB      = 10'b00_0000_0100,
		ST_RC      = 10'b00_0000_1000,
		ST_EVAL    = 10'b00_0001_0000,
		ST_WALK    = 10'b00_0010_0000,
		ST_WDRAIN  = 10'b00_0100_0000,
		ST_RESOLVE = 10'b00_1000_0000,
		ST_WRITE   = 10'b01_0000_0000,
		ST_DONE    = 10'b10_0000_0000
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       mvc_q;
	logic [MAW-1:0]         clr_idx_q;
	logic [VCW-1:0]         vcnt_q;
	logic [TCW-1:0]         tcnt_q;
	logic [NUM_W-1:0]       counter_q;
	logic [VCW-1:0]         walk_idx_q;
	logic                   walk_s1;
	logic [2:0]             wmask_q;
	logic                   result_valid_q;

	logic                   op_q;
	logic [2:0][CORNER_W-1:0] c_q;
	logic [2:0][SLOT_W-1:0] v_q;
	logic [2:0][SLOT_W-1:0] e_q;
	result_t                res_q;
	result_t                result_q;

	logic [2:0][CORNER_W-1:0] in_c;
	logic                   accept;
	logic                   in_err;
	result_t                res_in;
	logic [2:0][SLOT_W-1:0] slot_rd;
	logic [1:0]             ucnt;
	logic                   close_now;
	slot_assign_t           asg;
	logic [VCW-1:0]         vcnt_next;
	logic [2:0]             wbit;
	logic [1:0]             wsel;
	logic                   out_load;

	logic                   map_we;
	logic [MAW-1:0]         map_waddr;
	logic [SLOT_W-1:0]      map_wdata;
	logic [MAW-1:0]         map_raddr;
	logic [SLOT_W-1:0]      map_rdata;
	logic                   list_we;
	logic [CORNER_W-1:0]    list_rdata;

	assign in_c[0] = item.corner_a;
	assign in_c[1] = item.corner_b;
	assign in_c[2] = item.corner_c;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_load     = (state_q == ST_DONE) && (!result_valid_q || result_ready);

	always_comb begin
		in_err = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (({1'b0, in_c[k]} >= mvc_q) || (32'(in_c[k]) >= MAXV)) begin
				in_err = 1'b1;
			end
		end
	end

	always_comb begin
		res_in = '0;
		if (item.opcode == OP_END) begin
			if (vcnt_q != '0) begin
				res_in.closed           = 1'b1;
				res_in.closed_vertices  = COUNT_W'(vcnt_q);
				res_in.closed_triangles = COUNT_W'(tcnt_q);
			end
		end else if (in_err) begin
			res_in.meshlet_number = counter_q;
			res_in.index_error    = 1'b1;
		end
	end

	assign slot_rd[0] = v_q[0];
	assign slot_rd[1] = v_q[1];
	assign slot_rd[2] = (state_q == ST_EVAL) ? map_rdata : v_q[2];

	assign ucnt = 2'((slot_rd[0] == SLOT_UNUSED)) + 2'((slot_rd[1] == SLOT_UNUSED))
		+ 2'((slot_rd[2] == SLOT_UNUSED));
	assign close_now = ((SUMW'(vcnt_q) + SUMW'(ucnt)) > VCAP_S) || (tcnt_q >= TCAP_V);

	gmb_slot_assign #(
		.VCAP(MESHLET_VERTEX_CAP),
		.VCW (VCW)
	) u_assign (
		.corner (c_q),
		.slot_rd(slot_rd),
		.cleared(state_q == ST_RESOLVE),
		.vcnt   (vcnt_q),
		.asg    (asg)
	);

	assign vcnt_next = vcnt_q + VCW'($countones(asg.fresh));
	assign wbit      = wmask_q & (~wmask_q + 3'd1);
	assign wsel      = wbit[0] ? 2'd0 : (wbit[1] ? 2'd1 : 2'd2);

	always_comb begin
		map_we    = 1'b0;
		map_waddr = MAW'(c_q[wsel]);
		map_wdata = e_q[wsel];
		if (state_q == ST_CLEAR) begin
			map_we    = 1'b1;
			map_waddr = clr_idx_q;
			map_wdata = SLOT_UNUSED;
		end else if (walk_s1) begin
			map_we    = 1'b1;
			map_waddr = MAW'(list_rdata);
			map_wdata = SLOT_UNUSED;
		end else if (state_q == ST_WRITE) begin
			map_we = 1'b1;
		end
	end

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				map_raddr = MAW'(item.corner_a);
			end
			ST_RB: begin
				map_raddr = MAW'(c_q[1]);
			end
			ST_RC: begin
				map_raddr = MAW'(c_q[2]);
			end
			default: begin
				map_raddr = MAW'(c_q[0]);
			end
		endcase
	end

	assign list_we = (state_q == ST_WRITE);

	gmb_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_MESH_VERTICES)
	) u_slot_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	gmb_ram #(
		.WIDTH(CORNER_W),
		.DEPTH(MESHLET_VERTEX_CAP)
	) u_vertex_list (
		.clk  (clk),
		.we   (list_we),
		.waddr(e_q[wsel][LAW-1:0]),
		.wdata(c_q[wsel]),
		.raddr(walk_idx_q[LAW-1:0]),
		.rdata(list_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			mvc_q          <= CFG_RESET;
			clr_idx_q      <= '0;
			vcnt_q         <= '0;
			tcnt_q         <= '0;
			counter_q      <= '0;
			walk_idx_q     <= '0;
			walk_s1        <= 1'b0;
			wmask_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mvc_q <= cfg_wr_data;
			end
			walk_s1 <= (state_q == ST_WALK);
			if (result_valid_q && result_ready && !out_load) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + MAW'(1);
					if (clr_idx_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (item.opcode == OP_END) begin
							if (vcnt_q != '0) begin
								walk_idx_q <= '0;
								state_q    <= ST_WALK;
							end else begin
								counter_q <= '0;
								state_q   <= ST_DONE;
							end
						end else if (in_err) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RB;
						end
					end
				end
				ST_RB: begin
					state_q <= ST_RC;
				end
				ST_RC: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (close_now) begin
						if (vcnt_q != '0) begin
							walk_idx_q <= '0;
							state_q    <= ST_WALK;
						end else begin
							tcnt_q    <= '0;
							counter_q <= counter_q + NUM_W'(1);
							state_q   <= ST_RESOLVE;
						end
					end else begin
						vcnt_q  <= vcnt_next;
						tcnt_q  <= tcnt_q + TCW'(1);
						wmask_q <= asg.fresh;
						state_q <= (asg.fresh != '0) ? ST_WRITE : ST_DONE;
					end
				end
				ST_WALK: begin
					if (walk_idx_q == vcnt_q - VCW'(1)) begin
						state_q <= ST_WDRAIN;
					end else begin
						walk_idx_q <= walk_idx_q + VCW'(1);
					end
				end
				ST_WDRAIN: begin
					vcnt_q <= '0;
					tcnt_q <= '0;
					if (op_q == OP_END) begin
						counter_q <= '0;
						state_q   <= ST_DONE;
					end else begin
						counter_q <= counter_q + NUM_W'(1);
						state_q   <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					vcnt_q  <= vcnt_next;
					tcnt_q  <= tcnt_q + TCW'(1);
					wmask_q <= asg.fresh;
					state_q <= (asg.fresh != '0) ? ST_WRITE : ST_DONE;
				end
				ST_WRITE: begin
					wmask_q <= wmask_q & ~wbit;
					if ((wmask_q & ~wbit) == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q  <= item.opcode;
					c_q   <= in_c;
					res_q <= res_in;
				end
			end
			ST_RB: begin
				v_q[0] <= map_rdata;
			end
			ST_RC: begin
				v_q[1] <= map_rdata;
			end
			ST_EVAL: begin
				v_q[2] <= map_rdata;
				if (close_now) begin
					res_q.closed           <= 1'b1;
					res_q.closed_vertices  <= COUNT_W'(vcnt_q);
					res_q.closed_triangles <= COUNT_W'(tcnt_q);
				end else begin
					e_q                  <= asg.slot;
					res_q.local_a        <= asg.slot[0][LOCAL_W-1:0];
					res_q.local_b        <= asg.slot[1][LOCAL_W-1:0];
					res_q.local_c        <= asg.slot[2][LOCAL_W-1:0];
					res_q.new_mask       <= asg.fresh;
					res_q.meshlet_number <= counter_q;
				end
			end
			ST_RESOLVE: begin
				e_q                  <= asg.slot;
				res_q.local_a        <= asg.slot[0][LOCAL_W-1:0];
				res_q.local_b        <= asg.slot[1][LOCAL_W-1:0];
				res_q.local_c        <= asg.slot[2][LOCAL_W-1:0];
				res_q.new_mask       <= asg.fresh;
				res_q.meshlet_number <= counter_q;
			end
			ST_DONE: begin
				if (out_load) begin
					result_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/gmb_checker.sv
// Port-level checks for greedy_meshlet_builder_core, attached by bind.
// Uses gmb_pkg.
`timescale 1ns / 1ps

module gmb_checker import gmb_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.index_error |->
			!result.closed && result.new_mask == 3'b000)
		else $error("dropped triangle closed or appended");

	a_open_counts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.closed |->
			result.closed_vertices == '0 && result.closed_triangles == '0)
		else $error("counts reported without a close");

	a_fresh_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.new_mask == 3'b111 |->
			result.local_b == result.local_a + 6'd1 &&
			result.local_c == result.local_b + 6'd1)
		else $error("new slots not consecutive");

endmodule

bind greedy_meshlet_builder_core gmb_checker u_gmb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

### tb/sv/greedy_meshlet_builder_core_tb.sv
// Self-checking testbench for greedy_meshlet_builder_core: random triangle streams
// with bursty sender and stalling receiver, checked against an in-bench meshlet predictor.
// Depends on gmb_pkg and greedy_meshlet_builder_core.
`timescale 1ns / 1ps

module greedy_meshlet_builder_core_tb;
	import gmb_pkg::*;

	localparam int MAX_VERTS     = 65536;
	localparam int VERTEX_CAP    = 64;
	localparam int TRIANGLE_CAP  = 126;
	localparam int STALL_LIMIT   = 4 * MAX_VERTS;
	localparam int DRAIN_EVERY   = 150;
	localparam int SETTLE_CYCLES = 100;
	localparam int NUM_PHASES    = 6;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	item_t            item = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;

	// predictor state
	logic [SLOT_W-1:0]   map_slot [MAX_VERTS];
	logic [CORNER_W-1:0] vert_list [VERTEX_CAP];
	int                  open_vertices;
	int                  open_triangles;
	logic [NUM_W-1:0]    meshlet_seq;
	int                  vertex_limit;

	item_t   tri_stream [$];
	result_t predicted_results [$];
	result_t want;
	int      items_sent;
	int      results_seen;
	int      sent_now;
	int      burst_left;
	int      gap_left;
	int      stall_mode;
	int      stall_left;
	int      idle_cycles;
	int      failures;
	int      window_base;
	int      window_span;

	int unsigned phase_limit [NUM_PHASES] = '{65536, 1, 97, 300, 5000, 65536};
	int          phase_items [NUM_PHASES] = '{300, 60, 240, 240, 240, 240};

	greedy_meshlet_builder_core #(
		.MAX_MESH_VERTICES   (MAX_VERTS),
		.MESHLET_VERTEX_CAP  (VERTEX_CAP),
		.MESHLET_TRIANGLE_CAP(TRIANGLE_CAP)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #2 clk = ~clk;

	function automatic void retire_meshlet(inout result_t r);
		r.closed = 1'b1;
		r.closed_vertices = COUNT_W'(open_vertices);
		r.closed_triangles = COUNT_W'(open_triangles);
		for (int j = 0; j < open_vertices; j++)
			map_slot[vert_list[j]] = SLOT_UNUSED;
		open_vertices = 0;
		open_triangles = 0;
	endfunction

	function automatic result_t predict_meshlet(item_t it);
		result_t             r;
		logic [CORNER_W-1:0] corner [3];
		logic [LOCAL_W-1:0]  slot [3];
		int                  fresh;
		logic                bad;
		r = '0;
		if (it.opcode == OP_END) begin
			if (open_vertices > 0)
				retire_meshlet(r);
			meshlet_seq = '0;
			return r;
		end
		corner[0] = it.corner_a;
		corner[1] = it.corner_b;
		corner[2] = it.corner_c;
		bad = 1'b0;
		fresh = 0;
		for (int k = 0; k < 3; k++) begin
			if (int'(corner[k]) >= vertex_limit)
				bad = 1'b1;
			if (map_slot[corner[k]] == SLOT_UNUSED)
				fresh++;
		end
		if (bad) begin
			r.meshlet_number = meshlet_seq;
			r.index_error = 1'b1;
			return r;
		end
		if (open_vertices + fresh > VERTEX_CAP || open_triangles + 1 > TRIANGLE_CAP) begin
			retire_meshlet(r);
			meshlet_seq++;
		end
		for (int k = 0; k < 3; k++) begin
			if (map_slot[corner[k]] == SLOT_UNUSED && open_vertices < VERTEX_CAP) begin
				map_slot[corner[k]] = SLOT_W'(open_vertices);
				vert_list[open_vertices] = corner[k];
				open_vertices++;
				r.new_mask[k] = 1'b1;
			end
			slot[k] = map_slot[corner[k]][LOCAL_W-1:0];
		end
		open_triangles++;
		r.meshlet_number = meshlet_seq;
		r.local_a = slot[0];
		r.local_b = slot[1];
		r.local_c = slot[2];
		return r;
	endfunction

	function automatic item_t mk_item(logic op, int a, int b, int c);
		item_t it;
		it.opcode = op;
		it.corner_a = CORNER_W'(a);
		it.corner_b = CORNER_W'(b);
		it.corner_c = CORNER_W'(c);
		return it;
	endfunction

	// mostly mesh-like triangles from a drifting index window, plus noise
	function automatic item_t draw_item();
		item_t it;
		int    pick;
		int    span_kind;
		if ($urandom_range(39) == 0) begin
			span_kind = $urandom_range(2);
			window_span = (span_kind == 0) ? $urandom_range(16, 4) :
				(span_kind == 1) ? $urandom_range(80, 17) : $urandom_range(400, 81);
			window_base = $urandom_range(vertex_limit - 1);
		end
		it = mk_item(OP_TRI, $urandom_range(65535), $urandom_range(65535),
			$urandom_range(65535));
		pick = $urandom_range(99);
		if (pick < 3) begin
			it.opcode = OP_END;
		end else if (pick >= 8) begin
			it.corner_a = CORNER_W'((window_base + $urandom_range(window_span - 1)) % vertex_limit);
			it.corner_b = CORNER_W'((window_base + $urandom_range(window_span - 1)) % vertex_limit);
			it.corner_c = CORNER_W'((window_base + $urandom_range(window_span - 1)) % vertex_limit);
			if (pick < 14) begin
				case ($urandom_range(2))
					0: it.corner_b = it.corner_a;
					1: it.corner_c = it.corner_a;
					default: begin
						it.corner_b = it.corner_a;
						it.corner_c = it.corner_a;
					end
				endcase
			end else if (pick < 19 && vertex_limit < 65536) begin
				case ($urandom_range(2))
					0: it.corner_a = CORNER_W'($urandom_range(65535, vertex_limit));
					1: it.corner_b = CORNER_W'($urandom_range(65535, vertex_limit));
					default: it.corner_c = CORNER_W'($urandom_range(65535, vertex_limit));
				endcase
			end
		end
		return it;
	endfunction

	task automatic compare_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			if (failures < 10)
				$display("result %0d %s: expected %0h, got %0h", results_seen, field, exp_v,
					got_v);
			failures++;
		end
	endtask

	task automatic wait_idle();
		while (tri_stream.size() != 0 || item_valid || results_seen != items_sent)
			@(negedge clk);
	endtask

	task automatic set_vertex_limit(int unsigned v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CFG_W'(v);
		vertex_limit = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			items_sent <= 0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			sent_now = items_sent;
			if (item_valid && item_ready) begin
				predicted_results.push_back(predict_meshlet(item));
				sent_now = items_sent + 1;
				items_sent <= sent_now;
			end
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (tri_stream.size() != 0 &&
						!(sent_now % DRAIN_EVERY == DRAIN_EVERY / 2 &&
						results_seen != sent_now)) begin
					item <= tri_stream.pop_front();
					item_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(48, 1);
						gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			results_seen <= 0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (predicted_results.size() == 0) begin
					if (failures < 10)
						$display("result %0d: unexpected transfer %h", results_seen, result);
					failures++;
				end else begin
					want = predicted_results.pop_front();
					compare_field("closed", 32'(want.closed), 32'(result.closed));
					compare_field("closed_vertices", 32'(want.closed_vertices),
						32'(result.closed_vertices));
					compare_field("closed_triangles", 32'(want.closed_triangles),
						32'(result.closed_triangles));
					compare_field("meshlet_number", 32'(want.meshlet_number),
						32'(result.meshlet_number));
					compare_field("local_a", 32'(want.local_a), 32'(result.local_a));
					compare_field("local_b", 32'(want.local_b), 32'(result.local_b));
					compare_field("local_c", 32'(want.local_c), 32'(result.local_c));
					compare_field("new_mask", 32'(want.new_mask), 32'(result.new_mask));
					compare_field("index_error", 32'(want.index_error),
						32'(result.index_error));
				end
			end
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(2);
				stall_left <= $urandom_range(200, 20);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(1));
				default: result_ready <= ($urandom_range(7) == 0);
			endcase
		end
	end

	// watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < MAX_VERTS; i++)
			map_slot[i] = SLOT_UNUSED;
		open_vertices = 0;
		open_triangles = 0;
		meshlet_seq = '0;
		vertex_limit = int'(CFG_RESET);
		failures = 0;
		window_base = 0;
		window_span = 16;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			set_vertex_limit(phase_limit[p]);
			case (p)
				0: begin
					tri_stream.push_back(mk_item(OP_END, 0, 0, 0));
					tri_stream.push_back(mk_item(OP_TRI, 0, 0, 0));
					tri_stream.push_back(mk_item(OP_TRI, 65535, 65534, 65535));
					tri_stream.push_back(mk_item(OP_TRI, 'h5555, 'haaaa, 0));
					tri_stream.push_back(mk_item(OP_TRI, 'haaaa, 'h5555, 'hffff));
					tri_stream.push_back(mk_item(OP_END, 'hffff, 'hffff, 'hffff));
					tri_stream.push_back(mk_item(OP_END, 0, 0, 0));
				end
				1: begin
					tri_stream.push_back(mk_item(OP_TRI, 0, 0, 0));
					tri_stream.push_back(mk_item(OP_TRI, 1, 0, 0));
					tri_stream.push_back(mk_item(OP_TRI, 0, 1, 0));
					tri_stream.push_back(mk_item(OP_TRI, 0, 0, 1));
					tri_stream.push_back(mk_item(OP_TRI, 65535, 65535, 65535));
					tri_stream.push_back(mk_item(OP_END, 0, 0, 0));
				end
				2: begin
					tri_stream.push_back(mk_item(OP_TRI, 96, 95, 94));
					tri_stream.push_back(mk_item(OP_TRI, 97, 0, 0));
				end
				default: ;
			endcase
			for (int n = 0; n < phase_items[p]; n++)
				tri_stream.push_back(draw_item());
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && predicted_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/gmb_pkg.sv
hw/rtl/gmb_ram.sv
hw/rtl/gmb_slot_assign.sv
hw/rtl/greedy_meshlet_builder_core.sv
hw/rtl/gmb_checker.sv
tb/sv/greedy_meshlet_builder_core_tb.sv
